/* hw/rtl/ifs_pkg.sv */
// shared types, constants and coefficient tables for the fern point generator
package ifs_pkg;

    localparam int FRAC_BITS = 15;
    localparam int DATA_W    = 32;
    localparam int PIX_W     = 11;
    localparam int THR_W     = 31;
    localparam int SCALE_W   = 23;
    localparam int POS_W     = 10;
    localparam int CFG_W     = 31;
    localparam int IDX_W     = 3;
    localparam int WIDE_W    = DATA_W + 2;

    // map coefficients: decimal value times 2^FRAC_BITS, truncated toward zero
    localparam logic signed [DATA_W-1:0] COEF_016 =
        DATA_W'((longint'(16) * (longint'(1) <<< FRAC_BITS)) / 100);
    localparam logic signed [DATA_W-1:0] COEF_085 =
        DATA_W'((longint'(85) * (longint'(1) <<< FRAC_BITS)) / 100);
    localparam logic signed [DATA_W-1:0] COEF_004 =
        DATA_W'((longint'(4) * (longint'(1) <<< FRAC_BITS)) / 100);
    localparam logic signed [DATA_W-1:0] COEF_160 =
        DATA_W'((longint'(160) * (longint'(1) <<< FRAC_BITS)) / 100);
    localparam logic signed [DATA_W-1:0] COEF_020 =
        DATA_W'((longint'(20) * (longint'(1) <<< FRAC_BITS)) / 100);
    localparam logic signed [DATA_W-1:0] COEF_026 =
        DATA_W'((longint'(26) * (longint'(1) <<< FRAC_BITS)) / 100);
    localparam logic signed [DATA_W-1:0] COEF_023 =
        DATA_W'((longint'(23) * (longint'(1) <<< FRAC_BITS)) / 100);
    localparam logic signed [DATA_W-1:0] COEF_022 =
        DATA_W'((longint'(22) * (longint'(1) <<< FRAC_BITS)) / 100);
    localparam logic signed [DATA_W-1:0] COEF_015 =
        DATA_W'((longint'(15) * (longint'(1) <<< FRAC_BITS)) / 100);
    localparam logic signed [DATA_W-1:0] COEF_028 =
        DATA_W'((longint'(28) * (longint'(1) <<< FRAC_BITS)) / 100);
    localparam logic signed [DATA_W-1:0] COEF_024 =
        DATA_W'((longint'(24) * (longint'(1) <<< FRAC_BITS)) / 100);
    localparam logic signed [DATA_W-1:0] COEF_044 =
        DATA_W'((longint'(44) * (longint'(1) <<< FRAC_BITS)) / 100);

    localparam logic signed [PIX_W-1:0] PIX_MIN = -(PIX_W'(1) <<< (PIX_W - 1));
    localparam logic signed [PIX_W-1:0] PIX_MAX = ~PIX_MIN;

    localparam logic [1:0] MAP_STEM  = 2'd0;
    localparam logic [1:0] MAP_MAIN  = 2'd1;
    localparam logic [1:0] MAP_LEFT  = 2'd2;
    localparam logic [1:0] MAP_RIGHT = 2'd3;

    typedef enum logic [IDX_W-1:0] {
        REG_THR_ONE   = 3'd0,
        REG_THR_TWO   = 3'd1,
        REG_THR_THREE = 3'd2,
        REG_SCALE     = 3'd3,
        REG_COL_OFS   = 3'd4,
        REG_ROW_BASE  = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [THR_W-1:0]   thr_one;
        logic [THR_W-1:0]   thr_two;
        logic [THR_W-1:0]   thr_three;
        logic [SCALE_W-1:0] plot_scale;
        logic [POS_W-1:0]   column_offset;
        logic [POS_W-1:0]   row_base;
    } cfg_t;

    // term k: 0 x coef of x', 1 y coef of x', 2 x coef of y', 3 y coef of y'
    function automatic logic signed [DATA_W-1:0] map_coef(input logic [1:0] map,
                                                          input logic [1:0] term);
        logic signed [DATA_W-1:0] c;
        c = '0;
        case (map)
            MAP_STEM:
            begin
                c = (term == 2'd3) ? COEF_016 : '0;
            end
            MAP_MAIN:
            begin
                case (term)
                    2'd0:    c = COEF_085;
                    2'd1:    c = COEF_004;
                    2'd2:    c = -COEF_004;
                    default: c = COEF_085;
                endcase
            end
            MAP_LEFT:
            begin
                case (term)
                    2'd0:    c = COEF_020;
                    2'd1:    c = COEF_026;
                    2'd2:    c = COEF_023;
                    default: c = COEF_022;
                endcase
            end
            default:
            begin
                case (term)
                    2'd0:    c = -COEF_015;
                    2'd1:    c = COEF_028;
                    2'd2:    c = COEF_026;
                    default: c = COEF_024;
                endcase
            end
        endcase
        return c;
    endfunction

    function automatic logic signed [DATA_W-1:0] map_y_offset(input logic [1:0] map);
        logic signed [DATA_W-1:0] c;
        case (map)
            MAP_STEM:  c = '0;
            MAP_MAIN:  c = COEF_160;
            MAP_LEFT:  c = COEF_160;
            default:   c = COEF_044;
        endcase
        return c;
    endfunction

    function automatic logic signed [PIX_W-1:0] sat_pix(input logic signed [WIDE_W-1:0] v);
        logic signed [PIX_W-1:0] r;
        if (v < WIDE_W'(PIX_MIN))
            r = PIX_MIN;
        else if (v > WIDE_W'(PIX_MAX))
            r = PIX_MAX;
        else
            r = v[PIX_W-1:0];
        return r;
    endfunction

endpackage

/* hw/rtl/ifs_cfg_regs.sv */
// configuration register file of the fern point generator
module ifs_cfg_regs
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [ifs_pkg::IDX_W-1:0]    cfg_index,
    input  logic [ifs_pkg::CFG_W-1:0]    cfg_data,
    output ifs_pkg::cfg_t                cfg
);

    ifs_pkg::cfg_t cfg_reg;
    ifs_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                ifs_pkg::REG_THR_ONE:   cfg_next.thr_one   = cfg_data[ifs_pkg::THR_W-1:0];
                ifs_pkg::REG_THR_TWO:   cfg_next.thr_two   = cfg_data[ifs_pkg::THR_W-1:0];
                ifs_pkg::REG_THR_THREE: cfg_next.thr_three = cfg_data[ifs_pkg::THR_W-1:0];
                ifs_pkg::REG_SCALE:     cfg_next.plot_scale = cfg_data[ifs_pkg::SCALE_W-1:0];
                ifs_pkg::REG_COL_OFS:   cfg_next.column_offset = cfg_data[ifs_pkg::POS_W-1:0];
                ifs_pkg::REG_ROW_BASE:  cfg_next.row_base = cfg_data[ifs_pkg::POS_W-1:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.thr_one       <= ifs_pkg::THR_W'(21474835);
            cfg_reg.thr_two       <= ifs_pkg::THR_W'(1846835936);
            cfg_reg.thr_three     <= ifs_pkg::THR_W'(1997159792);
            cfg_reg.plot_scale    <= ifs_pkg::SCALE_W'(45 * (1 << ifs_pkg::FRAC_BITS));
            cfg_reg.column_offset <= ifs_pkg::POS_W'(320);
            cfg_reg.row_base      <= ifs_pkg::POS_W'(460);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hw/rtl/ifs_mul_unit.sv */
// shared fixed-point multiplier with registered, shifted and truncated product
module ifs_mul_unit
(
    input  logic                                clk,
    input  logic signed [ifs_pkg::DATA_W-1:0]   op_a,
    input  logic signed [ifs_pkg::DATA_W-1:0]   op_b,
    output logic signed [ifs_pkg::DATA_W-1:0]   prod
);

    logic signed [2*ifs_pkg::DATA_W-1:0] full_prod;
    logic signed [ifs_pkg::DATA_W-1:0]   prod_reg;

    // floor shift by the fraction bits is a plain bit select of the full product
    assign full_prod = op_a * op_b;

    always_ff @(posedge clk)
    begin
        prod_reg <= full_prod[ifs_pkg::FRAC_BITS + ifs_pkg::DATA_W - 1:ifs_pkg::FRAC_BITS];
    end

    assign prod = prod_reg;

endmodule

/* hw/rtl/ifs_fern_point_generator_top.sv */
// top level of the fern point generator: sequencer, point state and output beat
// each input beat goes through an accept step, six products through the one shared multiplier
//   and a drain step that forms the pixel row and loads the output register once it is free;
//   a new input beat is taken only after the current one is in the output register
// the output register holds a finished beat while the next input beat is already at work
// reset (rst_n, async low): point cleared to the origin, registers to their defaults, idle
module ifs_fern_point_generator_top
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [ifs_pkg::THR_W-1:0]            random_value,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [ifs_pkg::PIX_W-1:0]     pixel_column,
    output logic signed [ifs_pkg::PIX_W-1:0]     pixel_row,
    output logic signed [ifs_pkg::DATA_W-1:0]    point_x,
    output logic signed [ifs_pkg::DATA_W-1:0]    point_y,
    output logic [1:0]                           map_used,
    // configuration write port
    input  logic                                 cfg_we,
    input  logic [ifs_pkg::IDX_W-1:0]            cfg_index,
    input  logic [ifs_pkg::CFG_W-1:0]            cfg_data
);

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    ifs_pkg::cfg_t cfg;

    state_t state_reg, state_next;
    logic [2:0] step_reg, step_next;
    logic [1:0] map_reg, map_next;

    // point state and partial sums
    logic signed [ifs_pkg::DATA_W-1:0] cur_x_reg, cur_x_next;
    logic signed [ifs_pkg::DATA_W-1:0] cur_y_reg, cur_y_next;
    logic signed [ifs_pkg::DATA_W-1:0] acc_reg, acc_next;
    logic signed [ifs_pkg::PIX_W-1:0]  col_reg, col_next;

    // output beat registers
    logic                              out_valid_reg, out_valid_next;
    logic signed [ifs_pkg::PIX_W-1:0]  out_col_reg, out_col_next;
    logic signed [ifs_pkg::PIX_W-1:0]  out_row_reg, out_row_next;
    logic signed [ifs_pkg::DATA_W-1:0] out_x_reg, out_x_next;
    logic signed [ifs_pkg::DATA_W-1:0] out_y_reg, out_y_next;
    logic [1:0]                        out_map_reg, out_map_next;

    logic signed [ifs_pkg::DATA_W-1:0] mul_a;
    logic signed [ifs_pkg::DATA_W-1:0] mul_b;
    logic signed [ifs_pkg::DATA_W-1:0] prod;
    logic signed [ifs_pkg::DATA_W-1:0] prod_int;
    logic signed [ifs_pkg::WIDE_W-1:0] prod_int_wide;
    logic signed [ifs_pkg::DATA_W-1:0] scale_op;

    logic in_accept;
    logic out_free;
    logic [1:0] map_pick;

    ifs_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ifs_mul_unit u_mul_unit
    (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    // output register can take a new beat when empty or being drained this cycle
    assign out_free  = !out_valid_reg || !out_stall;

    // thresholds are tried in order; an empty range is never picked
    always_comb
    begin
        if (random_value < cfg.thr_one)
            map_pick = ifs_pkg::MAP_STEM;
        else if (random_value < cfg.thr_two)
            map_pick = ifs_pkg::MAP_MAIN;
        else if (random_value < cfg.thr_three)
            map_pick = ifs_pkg::MAP_LEFT;
        else
            map_pick = ifs_pkg::MAP_RIGHT;
    end

    // operand select for the shared multiplier
    // steps 0..3: map terms on x, y; step 4: scale * new x; step 5 and drain: scale * new y
    assign scale_op = ifs_pkg::DATA_W'(cfg.plot_scale);

    always_comb
    begin
        if (state_reg == ST_RUN && step_reg < 3'd4)
            mul_a = ifs_pkg::map_coef(map_reg, step_reg[1:0]);
        else
            mul_a = scale_op;
        case (step_reg) inside
            3'd0, 3'd2, 3'd4: mul_b = cur_x_reg;
            default:          mul_b = cur_y_reg;
        endcase
    end

    // integer part of a scaled coordinate, widened for the pixel add
    assign prod_int      = prod >>> ifs_pkg::FRAC_BITS;
    assign prod_int_wide = ifs_pkg::WIDE_W'(prod_int);

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        map_next       = map_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        acc_next       = acc_reg;
        col_next       = col_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_map_next   = out_map_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    map_next   = map_pick;
                    step_next  = 3'd0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                step_next = step_reg + 3'd1;
                case (step_reg)
                    3'd1:
                    begin
                        acc_next = prod;
                    end
                    3'd2:
                    begin
                        // left leaflet subtracts its y term rather than negating the coefficient
                        if (map_reg == ifs_pkg::MAP_LEFT)
                            cur_x_next = acc_reg - prod;
                        else
                            cur_x_next = acc_reg + prod;
                    end
                    3'd3:
                    begin
                        acc_next = prod;
                    end
                    3'd4:
                    begin
                        cur_y_next = acc_reg + prod + ifs_pkg::map_y_offset(map_reg);
                    end
                    3'd5:
                    begin
                        col_next = ifs_pkg::sat_pix(
                            ifs_pkg::WIDE_W'(cfg.column_offset) + prod_int_wide);
                        state_next = ST_DRAIN;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_DRAIN:
            begin
                // mul unit keeps producing scale * new y while waiting for the output side
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_col_next   = col_reg;
                    out_row_next   = ifs_pkg::sat_pix(
                        ifs_pkg::WIDE_W'(cfg.row_base) - prod_int_wide);
                    out_x_next     = cur_x_reg;
                    out_y_next     = cur_y_reg;
                    out_map_next   = map_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        map_reg     <= map_next;
        acc_reg     <= acc_next;
        col_reg     <= col_next;
        out_col_reg <= out_col_next;
        out_row_reg <= out_row_next;
        out_x_reg   <= out_x_next;
        out_y_reg   <= out_y_next;
        out_map_reg <= out_map_next;
    end

    assign out_valid    = out_valid_reg;
    assign pixel_column = out_col_reg;
    assign pixel_row    = out_row_reg;
    assign point_x      = out_x_reg;
    assign point_y      = out_y_reg;
    assign map_used     = out_map_reg;

    // an accepted beat always starts the product sequence at its first step
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == ST_RUN) && (step_reg == 3'd0))
        else $error("accepted beat did not start the sequence");

    // a new output beat is only loaded from the drain state
    a_out_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_next && !(out_valid_reg && out_stall)) |-> (state_reg == ST_DRAIN))
        else $error("output beat loaded outside the drain state");

    // the stem map always collapses x to zero
    a_stem_zero_x: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && map_used == ifs_pkg::MAP_STEM) |-> (point_x == '0))
        else $error("stem map produced nonzero x");

    // a waiting output beat is never overwritten by the next result
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(point_x) && $stable(point_y) && $stable(map_used))
        else $error("held output beat changed");

endmodule

/* tb/sv/ifs_fern_point_generator_top_test.sv */
// self-checking testbench for the fern point generator top level
module ifs_fern_point_generator_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    // fixed-point map coefficients, decimal value times 2^FRAC_BITS truncated toward zero
    localparam longint FERN_ONE  = longint'(1) <<< ifs_pkg::FRAC_BITS;
    localparam longint FERN_K16  = (longint'(16)  * FERN_ONE) / 100;
    localparam longint FERN_K85  = (longint'(85)  * FERN_ONE) / 100;
    localparam longint FERN_K04  = (longint'(4)   * FERN_ONE) / 100;
    localparam longint FERN_K160 = (longint'(160) * FERN_ONE) / 100;
    localparam longint FERN_K20  = (longint'(20)  * FERN_ONE) / 100;
    localparam longint FERN_K26  = (longint'(26)  * FERN_ONE) / 100;
    localparam longint FERN_K23  = (longint'(23)  * FERN_ONE) / 100;
    localparam longint FERN_K22  = (longint'(22)  * FERN_ONE) / 100;
    localparam longint FERN_K15  = (longint'(15)  * FERN_ONE) / 100;
    localparam longint FERN_K28  = (longint'(28)  * FERN_ONE) / 100;
    localparam longint FERN_K24  = (longint'(24)  * FERN_ONE) / 100;
    localparam longint FERN_K44  = (longint'(44)  * FERN_ONE) / 100;

    // register defaults after reset
    localparam logic [ifs_pkg::THR_W-1:0]   DEF_THR_ONE   = 31'd21474835;
    localparam logic [ifs_pkg::THR_W-1:0]   DEF_THR_TWO   = 31'd1846835936;
    localparam logic [ifs_pkg::THR_W-1:0]   DEF_THR_THREE = 31'd1997159792;
    localparam logic [ifs_pkg::SCALE_W-1:0] DEF_SCALE     = 23'd1474560;
    localparam logic [ifs_pkg::POS_W-1:0]   DEF_COL_OFS   = 10'd320;
    localparam logic [ifs_pkg::POS_W-1:0]   DEF_ROW_BASE  = 10'd460;

    localparam logic [ifs_pkg::THR_W-1:0]   THR_MAX   = {ifs_pkg::THR_W{1'b1}};
    localparam logic [ifs_pkg::SCALE_W-1:0] SCALE_MAX = {ifs_pkg::SCALE_W{1'b1}};
    localparam logic [ifs_pkg::POS_W-1:0]   POS_MAX   = {ifs_pkg::POS_W{1'b1}};

    // indexes with no register behind them, writes there must be ignored
    localparam logic [ifs_pkg::IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [ifs_pkg::IDX_W-1:0] REG_SPARE_B = 3'd7;

    // quiet time in clock cycles after the last result
    localparam int SETTLE_CYCLES = 16;

    typedef struct packed {
        logic [ifs_pkg::PIX_W-1:0]  column;
        logic [ifs_pkg::PIX_W-1:0]  row;
        logic [ifs_pkg::DATA_W-1:0] px;
        logic [ifs_pkg::DATA_W-1:0] py;
        logic [1:0]                 map;
    } fern_beat_t;

    // clock, reset and block ports; the driven inputs are known from time zero
    logic                              clk          = 1'b0;
    logic                              rst_n        = 1'b0;
    logic                              in_valid     = 1'b0;
    logic                              in_stall;
    logic [ifs_pkg::THR_W-1:0]         random_value = '0;
    logic                              out_valid;
    logic                              out_stall    = 1'b0;
    logic signed [ifs_pkg::PIX_W-1:0]  pixel_column;
    logic signed [ifs_pkg::PIX_W-1:0]  pixel_row;
    logic signed [ifs_pkg::DATA_W-1:0] point_x;
    logic signed [ifs_pkg::DATA_W-1:0] point_y;
    logic [1:0]                        map_used;
    logic                              cfg_we       = 1'b0;
    logic [ifs_pkg::IDX_W-1:0]         cfg_index    = '0;
    logic [ifs_pkg::CFG_W-1:0]         cfg_data     = '0;

    // predictor copy of the registers and of the stored point
    ifs_pkg::cfg_t                     fern_cfg;
    logic signed [ifs_pkg::DATA_W-1:0] fern_x;
    logic signed [ifs_pkg::DATA_W-1:0] fern_y;

    // predicted beats waiting for the block to deliver them
    fern_beat_t fern_expected[$];

    int beats_sent     = 0;
    int beats_checked  = 0;
    int mismatch_count = 0;

    // idling switches, tests turn them off for the steady tail
    bit src_idle_on  = 1'b1;
    bit sink_idle_on = 1'b1;

    ifs_fern_point_generator_top u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .random_value (random_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_column (pixel_column),
        .pixel_row    (pixel_row),
        .point_x      (point_x),
        .point_y      (point_y),
        .map_used     (map_used),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // fixed-point product: full 64-bit multiply, arithmetic shift, low 32 bits kept
    function automatic logic [ifs_pkg::DATA_W-1:0] fx_mul(
        input longint coef, input logic signed [ifs_pkg::DATA_W-1:0] v);
        longint prod;
        longint shifted;
        prod    = coef * longint'(v);
        shifted = prod >>> ifs_pkg::FRAC_BITS;
        return shifted[ifs_pkg::DATA_W-1:0];
    endfunction

    function automatic logic [ifs_pkg::PIX_W-1:0] clamp_pixel(input longint v);
        longint c;
        c = v;
        if (c < -1024)
            c = -1024;
        else if (c > 1023)
            c = 1023;
        return c[ifs_pkg::PIX_W-1:0];
    endfunction

    // one chaos-game step: pick the map, move the stored point, project to pixels
    function automatic fern_beat_t predict_fern_point(input logic [ifs_pkg::THR_W-1:0] rv);
        fern_beat_t                        beat;
        logic [1:0]                        map;
        logic signed [ifs_pkg::DATA_W-1:0] nx;
        logic signed [ifs_pkg::DATA_W-1:0] ny;
        logic signed [ifs_pkg::DATA_W-1:0] sx;
        logic signed [ifs_pkg::DATA_W-1:0] sy;
        logic signed [ifs_pkg::DATA_W-1:0] ix;
        logic signed [ifs_pkg::DATA_W-1:0] iy;
        if (rv < fern_cfg.thr_one)
        begin
            map = ifs_pkg::MAP_STEM;
            nx  = '0;
            ny  = fx_mul(FERN_K16, fern_y);
        end
        else if (rv < fern_cfg.thr_two)
        begin
            map = ifs_pkg::MAP_MAIN;
            nx  = fx_mul(FERN_K85, fern_x) + fx_mul(FERN_K04, fern_y);
            ny  = fx_mul(-FERN_K04, fern_x) + fx_mul(FERN_K85, fern_y)
                  + ifs_pkg::DATA_W'(FERN_K160);
        end
        else if (rv < fern_cfg.thr_three)
        begin
            map = ifs_pkg::MAP_LEFT;
            nx  = fx_mul(FERN_K20, fern_x) - fx_mul(FERN_K26, fern_y);
            ny  = fx_mul(FERN_K23, fern_x) + fx_mul(FERN_K22, fern_y)
                  + ifs_pkg::DATA_W'(FERN_K160);
        end
        else
        begin
            map = ifs_pkg::MAP_RIGHT;
            nx  = fx_mul(-FERN_K15, fern_x) + fx_mul(FERN_K28, fern_y);
            ny  = fx_mul(FERN_K26, fern_x) + fx_mul(FERN_K24, fern_y)
                  + ifs_pkg::DATA_W'(FERN_K44);
        end
        fern_x = nx;
        fern_y = ny;
        // scale is unsigned, so it widens with zeros
        sx = fx_mul(longint'(fern_cfg.plot_scale), nx);
        sy = fx_mul(longint'(fern_cfg.plot_scale), ny);
        ix = sx >>> ifs_pkg::FRAC_BITS;
        iy = sy >>> ifs_pkg::FRAC_BITS;
        beat.column = clamp_pixel(longint'(fern_cfg.column_offset) + longint'(ix));
        beat.row    = clamp_pixel(longint'(fern_cfg.row_base) - longint'(iy));
        beat.px     = nx;
        beat.py     = ny;
        beat.map    = map;
        return beat;
    endfunction

    // result checker and input tap share one process, output side first
    always @(posedge clk)
    begin
        fern_beat_t got;
        fern_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{pixel_column, pixel_row, point_x, point_y, map_used};
            if (fern_expected.size() == 0)
            begin
                $display("%0t: result beat with nothing expected (x %0d y %0d map %0d)",
                         $time, $signed(got.px), $signed(got.py), got.map);
                mismatch_count++;
            end
            else
            begin
                want = fern_expected.pop_front();
                if (got.column !== want.column)
                begin
                    $display("%0t: pixel_column expected %0d actual %0d",
                             $time, $signed(want.column), $signed(got.column));
                    mismatch_count++;
                end
                if (got.row !== want.row)
                begin
                    $display("%0t: pixel_row expected %0d actual %0d",
                             $time, $signed(want.row), $signed(got.row));
                    mismatch_count++;
                end
                if (got.px !== want.px)
                begin
                    $display("%0t: point_x expected %0d actual %0d",
                             $time, $signed(want.px), $signed(got.px));
                    mismatch_count++;
                end
                if (got.py !== want.py)
                begin
                    $display("%0t: point_y expected %0d actual %0d",
                             $time, $signed(want.py), $signed(got.py));
                    mismatch_count++;
                end
                if (got.map !== want.map)
                begin
                    $display("%0t: map_used expected %0d actual %0d",
                             $time, want.map, got.map);
                    mismatch_count++;
                end
            end
            beats_checked++;
        end
        // every accepted input beat moves the predicted point by one step
        if (rst_n && in_valid && !in_stall)
            fern_expected.push_back(predict_fern_point(random_value));
    end

    // receiver side: random stall bursts while enabled
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (sink_idle_on && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // offer one beat and hold it until the block takes it
    task automatic send_random_value(input logic [ifs_pkg::THR_W-1:0] rv);
        in_valid     <= 1'b1;
        random_value <= rv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        beats_sent++;
    endtask

    // occasional random sender gap, payload scrambled while idle
    task automatic maybe_pause_source();
        if (src_idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid     <= 1'b0;
            random_value <= ifs_pkg::THR_W'($urandom());
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    // hold the sender off until every predicted beat has been checked
    task automatic wait_fern_drained();
        in_valid <= 1'b0;
        while (beats_checked < beats_sent)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_fern_reg(input logic [ifs_pkg::IDX_W-1:0] idx,
                                  input logic [ifs_pkg::CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            ifs_pkg::REG_THR_ONE:   fern_cfg.thr_one       = data[ifs_pkg::THR_W-1:0];
            ifs_pkg::REG_THR_TWO:   fern_cfg.thr_two       = data[ifs_pkg::THR_W-1:0];
            ifs_pkg::REG_THR_THREE: fern_cfg.thr_three     = data[ifs_pkg::THR_W-1:0];
            ifs_pkg::REG_SCALE:     fern_cfg.plot_scale    = data[ifs_pkg::SCALE_W-1:0];
            ifs_pkg::REG_COL_OFS:   fern_cfg.column_offset = data[ifs_pkg::POS_W-1:0];
            ifs_pkg::REG_ROW_BASE:  fern_cfg.row_base      = data[ifs_pkg::POS_W-1:0];
            default:                ;
        endcase
        @(posedge clk);
    endtask

    // full register set, then a stray write to an unused index that must change nothing
    task automatic apply_settings(input logic [ifs_pkg::THR_W-1:0]   t1,
                                  input logic [ifs_pkg::THR_W-1:0]   t2,
                                  input logic [ifs_pkg::THR_W-1:0]   t3,
                                  input logic [ifs_pkg::SCALE_W-1:0] sc,
                                  input logic [ifs_pkg::POS_W-1:0]   co,
                                  input logic [ifs_pkg::POS_W-1:0]   rb);
        write_fern_reg(ifs_pkg::REG_THR_ONE, ifs_pkg::CFG_W'(t1));
        write_fern_reg(ifs_pkg::REG_THR_TWO, ifs_pkg::CFG_W'(t2));
        write_fern_reg(ifs_pkg::REG_THR_THREE, ifs_pkg::CFG_W'(t3));
        write_fern_reg(ifs_pkg::REG_SCALE, ifs_pkg::CFG_W'(sc));
        write_fern_reg(ifs_pkg::REG_COL_OFS, ifs_pkg::CFG_W'(co));
        write_fern_reg(ifs_pkg::REG_ROW_BASE, ifs_pkg::CFG_W'(rb));
        write_fern_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_A : REG_SPARE_B,
                       ifs_pkg::CFG_W'($urandom()));
        cfg_we <= 1'b0;
    endtask

    // random beats, a quarter of them right around one of the thresholds
    task automatic run_random_items(input int count, input int pause_at);
        longint                    pick;
        logic [ifs_pkg::THR_W-1:0] near;
        for (int i = 0; i < count; i++)
        begin
            if (i == pause_at)
                wait_fern_drained();
            if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       near = fern_cfg.thr_one;
                    1:       near = fern_cfg.thr_two;
                    default: near = fern_cfg.thr_three;
                endcase
                pick = longint'(near) + longint'($urandom_range(0, 4)) - 2;
                if (pick < 0)
                    pick = 0;
                if (pick > longint'(THR_MAX))
                    pick = longint'(THR_MAX);
                send_random_value(pick[ifs_pkg::THR_W-1:0]);
            end
            else
            begin
                send_random_value(ifs_pkg::THR_W'($urandom()));
            end
            maybe_pause_source();
        end
    endtask

    // map choice at reset defaults, including both sides of every threshold
    task automatic test_default_map_selection();
        send_random_value('0);
        send_random_value(fern_cfg.thr_one - 1'b1);
        send_random_value(fern_cfg.thr_one);
        maybe_pause_source();
        send_random_value(fern_cfg.thr_two - 1'b1);
        send_random_value(fern_cfg.thr_two);
        send_random_value(fern_cfg.thr_three - 1'b1);
        maybe_pause_source();
        send_random_value(fern_cfg.thr_three);
        send_random_value(THR_MAX);
        send_random_value(ifs_pkg::THR_W'(1) << (ifs_pkg::THR_W - 1));
        send_random_value(ifs_pkg::THR_W'(12345));
    endtask

    // register extremes, saturated pixels and thresholds out of order
    task automatic test_register_extremes();
        // all thresholds zero: only the right leaflet, full scale, top column offset, zero row base
        wait_fern_drained();
        apply_settings('0, '0, '0, SCALE_MAX, POS_MAX, '0);
        send_random_value('0);
        send_random_value(THR_MAX);
        send_random_value(ifs_pkg::THR_W'(1) << (ifs_pkg::THR_W - 2));
        // all thresholds at the top: stem everywhere but the largest value, zero scale
        wait_fern_drained();
        apply_settings(THR_MAX, THR_MAX, THR_MAX, '0, '0, POS_MAX);
        send_random_value(THR_MAX);
        send_random_value(THR_MAX - 1'b1);
        send_random_value('0);
        // second threshold below the first: main leaf range is empty
        wait_fern_drained();
        apply_settings(ifs_pkg::THR_W'(1) << 30, ifs_pkg::THR_W'(1) << 29,
                       ifs_pkg::THR_W'(3) << 29, SCALE_MAX, '0, '0);
        send_random_value(ifs_pkg::THR_W'(1) << 30);
        send_random_value(ifs_pkg::THR_W'(1) << 29);
        send_random_value(THR_MAX);
        send_random_value(ifs_pkg::THR_W'(3) << 29);
        // main leaf repeatedly at full scale drives the row well below the low limit
        wait_fern_drained();
        apply_settings(DEF_THR_ONE, DEF_THR_TWO, DEF_THR_THREE, SCALE_MAX, POS_MAX, '0);
        for (int i = 0; i < 5; i++)
            send_random_value(ifs_pkg::THR_W'(1) << 30);
        send_random_value(THR_MAX);
    endtask

    // random register sets, one phase with the sender held off mid-stream
    task automatic test_random_settings(input int phases, input int items);
        logic [ifs_pkg::THR_W-1:0]   t[3];
        logic [ifs_pkg::THR_W-1:0]   swap;
        logic [ifs_pkg::SCALE_W-1:0] sc;
        for (int p = 0; p < phases; p++)
        begin
            for (int k = 0; k < 3; k++)
                t[k] = ifs_pkg::THR_W'($urandom());
            // mostly ordered so that every map gets picked
            if ($urandom_range(0, 3) != 0)
            begin
                for (int a = 0; a < 2; a++)
                    for (int b = 0; b < 2 - a; b++)
                        if (t[b] > t[b + 1])
                        begin
                            swap     = t[b];
                            t[b]     = t[b + 1];
                            t[b + 1] = swap;
                        end
            end
            if ($urandom_range(0, 2) != 0)
                sc = ifs_pkg::SCALE_W'($urandom_range(0, 4 * DEF_SCALE));
            else
                sc = ifs_pkg::SCALE_W'($urandom());
            src_idle_on  = ($urandom_range(0, 3) != 0);
            sink_idle_on = ($urandom_range(0, 3) != 0);
            wait_fern_drained();
            apply_settings(t[0], t[1], t[2], sc, ifs_pkg::POS_W'($urandom()),
                           ifs_pkg::POS_W'($urandom()));
            run_random_items(items, (p == 1) ? items / 2 : -1);
        end
    endtask

    // closing stretch at full rate, no idling on either side
    task automatic test_steady_stream(input int items);
        wait_fern_drained();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        apply_settings(DEF_THR_ONE, DEF_THR_TWO, DEF_THR_THREE, DEF_SCALE,
                       DEF_COL_OFS, DEF_ROW_BASE);
        run_random_items(items, -1);
    endtask

    // run limit, several times the slowest legal run
    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        fern_cfg.thr_one       = DEF_THR_ONE;
        fern_cfg.thr_two       = DEF_THR_TWO;
        fern_cfg.thr_three     = DEF_THR_THREE;
        fern_cfg.plot_scale    = DEF_SCALE;
        fern_cfg.column_offset = DEF_COL_OFS;
        fern_cfg.row_base      = DEF_ROW_BASE;
        fern_x                 = '0;
        fern_y                 = '0;

        // reset held low from time zero, then released once
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_map_selection();
        test_register_extremes();
        test_random_settings(6, 135);
        test_steady_stream(110);

        wait_fern_drained();
        if (fern_expected.size() != 0)
        begin
            $display("%0t: %0d expected beats never arrived", $time, fern_expected.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
